// ===== hw/rtl/lwpw_pkg.sv =====
// Shared types and constants for the LCD window pixel writer.
// Holds field widths, mode and item-kind codes, controller command bytes
// and the queue entry layout. No dependencies.
package lwpw_pkg;

    // Field widths
    localparam int WORD_W  = 16;
    localparam int COORD_W = 9;     // screen sizes up to 511
    localparam int COUNT_W = 18;    // up to 511 x 511 pixels

    // Default geometry and queue size
    localparam int DEF_SCREEN_WIDTH  = 240;
    localparam int DEF_SCREEN_HEIGHT = 320;
    localparam int DEF_QUEUE_DEPTH   = 4;

    // Drawing modes
    localparam logic [1:0] MODE_FILL  = 2'd0;
    localparam logic [1:0] MODE_IMAGE = 2'd1;
    localparam logic [1:0] MODE_GLYPH = 2'd2;

    // Item kinds as classified by the front end
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DROP  = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    // Display controller command bytes
    localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
    localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

    // One classified item as it sits in the queue
    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         mode;
        logic [COORD_W-1:0] x_first;
        logic [COORD_W-1:0] x_last;
        logic [COORD_W-1:0] y_first;
        logic [COORD_W-1:0] y_last;
        logic [COORD_W-1:0] row_width;
        logic [COUNT_W-1:0] pixel_count;
        logic [WORD_W-1:0]  fore_color;
        logic [WORD_W-1:0]  back_color;
        logic [WORD_W-1:0]  data_value;
    } q_entry_t;

endpackage

// ===== hw/rtl/lwpw_if.sv =====
// Stream interfaces of the LCD window pixel writer: the command/data
// input channel and the display word output channel.
// Depends on lwpw_pkg for field widths.
interface lwpw_cmd_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [1:0]                  mode;
    logic [lwpw_pkg::WORD_W-1:0] x_first;
    logic [lwpw_pkg::WORD_W-1:0] y_first;
    logic [lwpw_pkg::WORD_W-1:0] x_last;
    logic [lwpw_pkg::WORD_W-1:0] y_last;
    logic [lwpw_pkg::WORD_W-1:0] fore_color;
    logic [lwpw_pkg::WORD_W-1:0] back_color;
    logic [lwpw_pkg::WORD_W-1:0] data_value;

    modport source (
        output valid, func, mode, x_first, y_first, x_last, y_last,
               fore_color, back_color, data_value,
        input  ready
    );
    modport sink (
        input  valid, func, mode, x_first, y_first, x_last, y_last,
               fore_color, back_color, data_value,
        output ready
    );
endinterface

interface lwpw_lcd_if;
    logic                        valid;
    logic                        ready;
    logic [lwpw_pkg::WORD_W-1:0] word;
    logic                        is_data;
    logic                        is_wide;
    logic                        last;

    modport source (
        output valid, word, is_data, is_wide, last,
        input  ready
    );
    modport sink (
        input  valid, word, is_data, is_wide, last,
        output ready
    );
endinterface

// ===== hw/rtl/lwpw_front.sv =====
// Front end: checks each incoming item and turns it into a queue entry
// (valid start, dropped start or data) with the window size worked out.
// Depends on lwpw_pkg and lwpw_if.
module lwpw_front #(
    parameter int SCREEN_WIDTH  = lwpw_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = lwpw_pkg::DEF_SCREEN_HEIGHT
) (
    lwpw_cmd_if.sink           cmd,
    input  logic               q_ready,
    output logic               q_push,
    output lwpw_pkg::q_entry_t q_entry
);
    import lwpw_pkg::*;

    logic               bad_window;
    logic [COORD_W-1:0] win_w;
    logic [COORD_W-1:0] win_h;

    // Window check: off screen, reversed or unknown mode
    always_comb
    begin
        bad_window = (cmd.x_first >= WORD_W'(SCREEN_WIDTH))
                  || (cmd.x_last  >= WORD_W'(SCREEN_WIDTH))
                  || (cmd.y_first >= WORD_W'(SCREEN_HEIGHT))
                  || (cmd.y_last  >= WORD_W'(SCREEN_HEIGHT))
                  || (cmd.x_first > cmd.x_last)
                  || (cmd.y_first > cmd.y_last)
                  || (cmd.mode > MODE_GLYPH);
    end

    // Window size; only meaningful for a good window
    assign win_w = cmd.x_last[COORD_W-1:0] - cmd.x_first[COORD_W-1:0] + COORD_W'(1);
    assign win_h = cmd.y_last[COORD_W-1:0] - cmd.y_first[COORD_W-1:0] + COORD_W'(1);

    // Build the queue entry
    always_comb
    begin
        if (cmd.func)
        begin
            q_entry.kind = KIND_DATA;
        end
        else if (bad_window)
        begin
            q_entry.kind = KIND_DROP;
        end
        else
        begin
            q_entry.kind = KIND_START;
        end
        q_entry.mode        = cmd.mode;
        q_entry.x_first     = cmd.x_first[COORD_W-1:0];
        q_entry.x_last      = cmd.x_last[COORD_W-1:0];
        q_entry.y_first     = cmd.y_first[COORD_W-1:0];
        q_entry.y_last      = cmd.y_last[COORD_W-1:0];
        q_entry.row_width   = win_w;
        q_entry.pixel_count = COUNT_W'(win_w) * COUNT_W'(win_h);
        q_entry.fore_color  = cmd.fore_color;
        q_entry.back_color  = cmd.back_color;
        q_entry.data_value  = cmd.data_value;
    end

    assign q_push    = cmd.valid;
    assign cmd.ready = q_ready;

endmodule

// ===== hw/rtl/lwpw_queue.sv =====
// Short queue between front and back end: classified entries in arrival
// order, first word visible at the head. Depends on lwpw_pkg.
module lwpw_queue #(
    parameter int DEPTH = lwpw_pkg::DEF_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lwpw_pkg::q_entry_t push_entry,
    output logic               push_ready,
    input  logic               pop,
    output logic               pop_valid,
    output lwpw_pkg::q_entry_t pop_entry
);
    import lwpw_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    q_entry_t          mem_reg [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_entry  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + ADDR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + ADDR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue fill count did not follow a push");

endmodule

// ===== hw/rtl/lwpw_back.sv =====
// Back end: sequences the window header bytes and the pixel words from
// queue entries, tracks the window state, and drives the output register.
// Depends on lwpw_pkg and lwpw_if.
module lwpw_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  lwpw_pkg::q_entry_t q_entry,
    output logic               q_pop,
    lwpw_lcd_if.source         lcd
);
    import lwpw_pkg::*;

    // Header byte positions
    localparam logic [3:0] HDR_COL_CMD = 4'd0;
    localparam logic [3:0] HDR_XF_HI   = 4'd1;
    localparam logic [3:0] HDR_XF_LO   = 4'd2;
    localparam logic [3:0] HDR_XL_HI   = 4'd3;
    localparam logic [3:0] HDR_XL_LO   = 4'd4;
    localparam logic [3:0] HDR_ROW_CMD = 4'd5;
    localparam logic [3:0] HDR_YF_HI   = 4'd6;
    localparam logic [3:0] HDR_YF_LO   = 4'd7;
    localparam logic [3:0] HDR_YL_HI   = 4'd8;
    localparam logic [3:0] HDR_YL_LO   = 4'd9;
    localparam logic [3:0] HDR_MEM_CMD = 4'd10;

    // Window state (control)
    logic               active_reg, active_next;
    logic               hdr_busy_reg, hdr_busy_next;
    logic               glyph_busy_reg, glyph_busy_next;
    logic               out_valid_reg, out_valid_next;
    // Window state (payload)
    logic [1:0]         mode_reg, mode_next;
    logic [COUNT_W-1:0] pixels_left_reg, pixels_left_next;
    logic [COORD_W-1:0] row_width_reg, row_width_next;
    logic [COORD_W-1:0] column_pos_reg, column_pos_next;
    logic [WORD_W-1:0]  fore_reg, fore_next;
    logic [WORD_W-1:0]  back_reg, back_next;
    logic [COORD_W-1:0] x_first_reg, x_first_next;
    logic [COORD_W-1:0] x_last_reg, x_last_next;
    logic [COORD_W-1:0] y_first_reg, y_first_next;
    logic [COORD_W-1:0] y_last_reg, y_last_next;
    logic [3:0]         hdr_idx_reg, hdr_idx_next;
    logic [7:0]         glyph_bits_reg, glyph_bits_next;
    logic [2:0]         glyph_idx_reg, glyph_idx_next;
    logic [WORD_W-1:0]  out_word_reg, out_word_next;
    logic               out_data_reg, out_data_next;
    logic               out_wide_reg, out_wide_next;
    logic               out_last_reg, out_last_next;

    logic               can_emit;
    logic               emit;
    logic [WORD_W-1:0]  emit_word;
    logic               emit_data;
    logic               pix_fire;
    logic [WORD_W-1:0]  pix_color;
    logic [COUNT_W-1:0] pl_dec;
    logic               fin;
    logic [COORD_W-1:0] col_inc;
    logic [COORD_W-1:0] col_adv;
    logic [WORD_W-1:0]  xf_w, xl_w, yf_w, yl_w;

    assign can_emit = !out_valid_reg || lcd.ready;

    // Pixel bookkeeping from the current state
    assign pl_dec  = pixels_left_reg - COUNT_W'(1);
    assign fin     = (pl_dec == '0);
    assign col_inc = column_pos_reg + COORD_W'(1);
    assign col_adv = (col_inc >= row_width_reg) ? '0 : col_inc;

    assign xf_w = WORD_W'(x_first_reg);
    assign xl_w = WORD_W'(x_last_reg);
    assign yf_w = WORD_W'(y_first_reg);
    assign yl_w = WORD_W'(y_last_reg);

    // Sequencer
    always_comb
    begin
        active_next      = active_reg;
        hdr_busy_next    = hdr_busy_reg;
        glyph_busy_next  = glyph_busy_reg;
        mode_next        = mode_reg;
        pixels_left_next = pixels_left_reg;
        row_width_next   = row_width_reg;
        column_pos_next  = column_pos_reg;
        fore_next        = fore_reg;
        back_next        = back_reg;
        x_first_next     = x_first_reg;
        x_last_next      = x_last_reg;
        y_first_next     = y_first_reg;
        y_last_next      = y_last_reg;
        hdr_idx_next     = hdr_idx_reg;
        glyph_bits_next  = glyph_bits_reg;
        glyph_idx_next   = glyph_idx_reg;
        q_pop            = 1'b0;
        emit             = 1'b0;
        emit_word        = '0;
        emit_data        = 1'b0;
        pix_fire         = 1'b0;
        pix_color        = fore_reg;

        if (can_emit)
        begin
            if (hdr_busy_reg)
            begin
                // Remaining header bytes
                emit      = 1'b1;
                emit_data = 1'b1;
                case (hdr_idx_reg)
                    HDR_XF_HI:
                    begin
                        emit_word = WORD_W'(xf_w[15:8]);
                    end
                    HDR_XF_LO:
                    begin
                        emit_word = WORD_W'(xf_w[7:0]);
                    end
                    HDR_XL_HI:
                    begin
                        emit_word = WORD_W'(xl_w[15:8]);
                    end
                    HDR_XL_LO:
                    begin
                        emit_word = WORD_W'(xl_w[7:0]);
                    end
                    HDR_ROW_CMD:
                    begin
                        emit_word = WORD_W'(CMD_ROW_SET);
                        emit_data = 1'b0;
                    end
                    HDR_YF_HI:
                    begin
                        emit_word = WORD_W'(yf_w[15:8]);
                    end
                    HDR_YF_LO:
                    begin
                        emit_word = WORD_W'(yf_w[7:0]);
                    end
                    HDR_YL_HI:
                    begin
                        emit_word = WORD_W'(yl_w[15:8]);
                    end
                    HDR_YL_LO:
                    begin
                        emit_word = WORD_W'(yl_w[7:0]);
                    end
                    HDR_MEM_CMD:
                    begin
                        emit_word = WORD_W'(CMD_MEMORY_WRITE);
                        emit_data = 1'b0;
                    end
                    default:
                    begin
                        emit_word = WORD_W'(CMD_COLUMN_SET);
                        emit_data = 1'b0;
                    end
                endcase
                hdr_idx_next = hdr_idx_reg + 4'd1;
                if (hdr_idx_reg == HDR_MEM_CMD)
                begin
                    hdr_busy_next = 1'b0;
                end
            end
            else if (glyph_busy_reg)
            begin
                // Further bits of the current glyph byte
                pix_fire        = 1'b1;
                pix_color       = glyph_bits_reg[7] ? fore_reg : back_reg;
                glyph_bits_next = {glyph_bits_reg[6:0], 1'b0};
                glyph_idx_next  = glyph_idx_reg + 3'd1;
                if (fin || (col_adv == '0) || (glyph_idx_reg == 3'd7))
                begin
                    glyph_busy_next = 1'b0;
                end
            end
            else if (q_valid)
            begin
                q_pop = 1'b1;
                case (q_entry.kind)
                    KIND_START:
                    begin
                        active_next      = 1'b1;
                        mode_next        = q_entry.mode;
                        pixels_left_next = q_entry.pixel_count;
                        row_width_next   = q_entry.row_width;
                        column_pos_next  = '0;
                        fore_next        = q_entry.fore_color;
                        back_next        = q_entry.back_color;
                        x_first_next     = q_entry.x_first;
                        x_last_next      = q_entry.x_last;
                        y_first_next     = q_entry.y_first;
                        y_last_next      = q_entry.y_last;
                        emit             = 1'b1;
                        emit_word        = WORD_W'(CMD_COLUMN_SET);
                        hdr_busy_next    = 1'b1;
                        hdr_idx_next     = HDR_XF_HI;
                    end
                    KIND_DROP:
                    begin
                        active_next = 1'b0;
                    end
                    KIND_DATA:
                    begin
                        if (active_reg)
                        begin
                            pix_fire = 1'b1;
                            case (mode_reg)
                                MODE_FILL:
                                begin
                                    pix_color = fore_reg;
                                end
                                MODE_IMAGE:
                                begin
                                    pix_color = q_entry.data_value;
                                end
                                default:
                                begin
                                    pix_color = q_entry.data_value[7] ? fore_reg : back_reg;
                                    glyph_bits_next = {q_entry.data_value[6:0], 1'b0};
                                    glyph_idx_next  = 3'd1;
                                    if (!fin && (col_adv != '0))
                                    begin
                                        glyph_busy_next = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        active_next = active_reg;
                    end
                endcase
            end
        end

        // One pixel out: count down, step the column, close on the last one
        if (pix_fire)
        begin
            emit             = 1'b1;
            emit_word        = pix_color;
            emit_data        = 1'b1;
            pixels_left_next = pl_dec;
            column_pos_next  = col_adv;
            if (fin)
            begin
                active_next = 1'b0;
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_data_next  = out_data_reg;
        out_wide_next  = out_wide_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_word_next  = emit_word;
            out_data_next  = emit_data;
            out_wide_next  = pix_fire;
            out_last_next  = pix_fire && fin;
        end
        else if (lcd.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            hdr_busy_reg   <= 1'b0;
            glyph_busy_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            hdr_busy_reg   <= hdr_busy_next;
            glyph_busy_reg <= glyph_busy_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        pixels_left_reg <= pixels_left_next;
        row_width_reg   <= row_width_next;
        column_pos_reg  <= column_pos_next;
        fore_reg        <= fore_next;
        back_reg        <= back_next;
        x_first_reg     <= x_first_next;
        x_last_reg      <= x_last_next;
        y_first_reg     <= y_first_next;
        y_last_reg      <= y_last_next;
        hdr_idx_reg     <= hdr_idx_next;
        glyph_bits_reg  <= glyph_bits_next;
        glyph_idx_reg   <= glyph_idx_next;
        out_word_reg    <= out_word_next;
        out_data_reg    <= out_data_next;
        out_wide_reg    <= out_wide_next;
        out_last_reg    <= out_last_next;
    end

    assign lcd.valid   = out_valid_reg;
    assign lcd.word    = out_word_reg;
    assign lcd.is_data = out_data_reg;
    assign lcd.is_wide = out_wide_reg;
    assign lcd.last    = out_last_reg;

    // Checks
    a_hdr_active: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_busy_reg |-> active_reg)
        else $error("header in progress without an open window");

    a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(hdr_busy_reg && glyph_busy_reg))
        else $error("header and glyph expansion both busy");

    a_glyph_mode: assert property (@(posedge clk) disable iff (!rst_n)
        glyph_busy_reg |-> (active_reg && (mode_reg == MODE_GLYPH)))
        else $error("glyph expansion outside a glyph window");

    a_last_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_wide_reg && out_data_reg && !active_reg))
        else $error("last marker on a non-pixel word or with window still open");

endmodule

// ===== hw/rtl/lcd_window_pixel_writer.sv =====
// Window pixel writer for an SPI display controller, RGB565 words out.
// Path: an accepted item is written into the queue, then the back end puts
// its first word in the output register. Throughput: the back-end sequencer
// gives one word per cycle while lcd is ready; words: start 11, glyph byte 1 to 8, data 1.
// Reset: queue empty, no window open, output register empty; no clear pass.
module lcd_window_pixel_writer #(
    parameter int SCREEN_WIDTH  = lwpw_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = lwpw_pkg::DEF_SCREEN_HEIGHT,
    parameter int QUEUE_DEPTH   = lwpw_pkg::DEF_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    lwpw_cmd_if.sink   cmd,
    lwpw_lcd_if.source lcd
);
    import lwpw_pkg::*;

    logic     push;
    logic     push_ready;
    q_entry_t push_entry;
    logic     pop;
    logic     pop_valid;
    q_entry_t pop_entry;

    // Classify incoming items
    lwpw_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .cmd     (cmd),
        .q_ready (push_ready),
        .q_push  (push),
        .q_entry (push_entry)
    );

    // Decoupling queue
    lwpw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry)
    );

    // Word sequencer and output register
    lwpw_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_entry (pop_entry),
        .q_pop   (pop),
        .lcd     (lcd)
    );

endmodule

// ===== tb/sv/lcd_window_pixel_writer_test.sv =====
// Self-checking testbench for lcd_window_pixel_writer: directed windows, a
// back-pressure phase and random window sequences, checked word by word.
// Depends on lwpw_pkg and the lwpw_cmd_if / lwpw_lcd_if stream interfaces.
module lcd_window_pixel_writer_test;

    import lwpw_pkg::*;

    localparam logic       FUNC_START  = 1'b0;
    localparam logic       FUNC_DATA   = 1'b1;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         SCR_W       = DEF_SCREEN_WIDTH;
    localparam int         SCR_H       = DEF_SCREEN_HEIGHT;
    localparam int         LONG_HOLD   = 160;
    localparam int         RANDOM_ITEMS = 110;

    typedef struct packed {
        logic        func;
        logic [1:0]  mode;
        logic [15:0] x_first;
        logic [15:0] y_first;
        logic [15:0] x_last;
        logic [15:0] y_last;
        logic [15:0] fore_color;
        logic [15:0] back_color;
        logic [15:0] data_value;
    } pixel_cmd_t;

    typedef struct packed {
        logic [15:0] word;
        logic        is_data;
        logic        is_wide;
        logic        last;
    } lcd_word_t;

    // Window state tracker and store of the display words still to come
    class window_scoreboard;
        lcd_word_t          expected_words[$];
        int                 errors;
        bit                 window_open;
        bit [1:0]           window_mode;
        bit [COUNT_W-1:0]   pixels_left;
        bit [COORD_W-1:0]   row_width;
        bit [COORD_W-1:0]   column_pos;
        bit [15:0]          fore;
        bit [15:0]          back;

        task report(string msg);
            $display("%0t: %s", $time, msg);
            errors++;
        endtask

        function void queue_word(bit [15:0] word, bit is_data, bit is_wide, bit last);
            lcd_word_t w;
            w.word    = word;
            w.is_data = is_data;
            w.is_wide = is_wide;
            w.last    = last;
            expected_words.push_back(w);
        endfunction

        function void queue_pixel(bit [15:0] color);
            bit fin;
            pixels_left = pixels_left - 1'b1;
            fin = (pixels_left == 0);
            queue_word(color, 1'b1, 1'b1, fin);
            column_pos = column_pos + 1'b1;
            if (column_pos >= row_width)
                column_pos = '0;
            if (fin)
                window_open = 1'b0;
        endfunction

        // Command byte followed by two 16-bit coordinates, high byte first
        function void queue_pair(bit [7:0] code, bit [15:0] a, bit [15:0] b);
            queue_word({8'h00, code}, 1'b0, 1'b0, 1'b0);
            queue_word({8'h00, a[15:8]}, 1'b1, 1'b0, 1'b0);
            queue_word({8'h00, a[7:0]}, 1'b1, 1'b0, 1'b0);
            queue_word({8'h00, b[15:8]}, 1'b1, 1'b0, 1'b0);
            queue_word({8'h00, b[7:0]}, 1'b1, 1'b0, 1'b0);
        endfunction

        // Returns the number of words the accepted item gives rise to
        function int note_item(pixel_cmd_t it);
            int before_n;
            before_n = expected_words.size();
            if (it.func == FUNC_START) begin
                // a new start always abandons the open window
                window_open = 1'b0;
                if (it.x_first < SCR_W && it.y_first < SCR_H &&
                    it.x_last < SCR_W && it.y_last < SCR_H &&
                    it.x_first <= it.x_last && it.y_first <= it.y_last &&
                    it.mode <= MODE_GLYPH) begin
                    queue_pair(CMD_COLUMN_SET, it.x_first, it.x_last);
                    queue_pair(CMD_ROW_SET, it.y_first, it.y_last);
                    queue_word({8'h00, CMD_MEMORY_WRITE}, 1'b0, 1'b0, 1'b0);
                    window_open = 1'b1;
                    window_mode = it.mode;
                    row_width   = COORD_W'(it.x_last - it.x_first + 16'd1);
                    pixels_left = COUNT_W'(row_width) *
                                  COUNT_W'(it.y_last - it.y_first + 16'd1);
                    column_pos  = '0;
                    fore        = it.fore_color;
                    back        = it.back_color;
                end
            end else if (window_open) begin
                case (window_mode)
                    MODE_FILL:  queue_pixel(fore);
                    MODE_IMAGE: queue_pixel(it.data_value);
                    default:
                    begin
                        // glyph byte, MSB first; stops at row end or window end
                        for (int b = 7; b >= 0; b--) begin
                            queue_pixel(it.data_value[b] ? fore : back);
                            if (!window_open || column_pos == 0)
                                break;
                        end
                    end
                endcase
            end
            return expected_words.size() - before_n;
        endfunction

        task check_word(lcd_word_t got);
            lcd_word_t want;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word %h is_data %b is_wide %b last %b",
                                 got.word, got.is_data, got.is_wide, got.last));
                return;
            end
            want = expected_words.pop_front();
            if (got.word !== want.word || got.is_data !== want.is_data ||
                got.is_wide !== want.is_wide || got.last !== want.last)
                report($sformatf("word %h/%b/%b/%b, wanted %h/%b/%b/%b",
                                 got.word, got.is_data, got.is_wide, got.last,
                                 want.word, want.is_data, want.is_wide, want.last));
        endtask
    endclass

    logic clk;
    logic rst_n;

    lwpw_cmd_if cmd_ch ();
    lwpw_lcd_if lcd_ch ();

    lcd_window_pixel_writer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .lcd   (lcd_ch)
    );

    window_scoreboard sb = new();
    bit idle_on   = 1'b1;
    bit hold_req  = 1'b0;
    int busy_items = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Overall time limit
    initial
    begin
        #10_000_000;
        $display("lcd_window_pixel_writer: mismatch");
        $finish;
    end

    // Output monitor: values read here are those before the edge
    always @(posedge clk)
    begin
        if (rst_n && lcd_ch.valid && lcd_ch.ready)
            sb.check_word({lcd_ch.word, lcd_ch.is_data, lcd_ch.is_wide, lcd_ch.last});
    end

    // Receiver ready: random stall bursts, plus one long hold on request
    initial
    begin
        lcd_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req) begin
                hold_req = 1'b0;
                lcd_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                lcd_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end else begin
                lcd_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    function automatic pixel_cmd_t start_cmd(logic [1:0] mode, logic [15:0] x1,
                                             logic [15:0] y1, logic [15:0] x2,
                                             logic [15:0] y2, logic [15:0] fore,
                                             logic [15:0] back);
        pixel_cmd_t it;
        it.func       = FUNC_START;
        it.mode       = mode;
        it.x_first    = x1;
        it.y_first    = y1;
        it.x_last     = x2;
        it.y_last     = y2;
        it.fore_color = fore;
        it.back_color = back;
        it.data_value = 16'($urandom);
        return it;
    endfunction

    // Data item; the start-only fields carry noise the block must ignore
    function automatic pixel_cmd_t data_cmd(logic [15:0] dv);
        pixel_cmd_t   it;
        logic [127:0] noise;
        noise         = {$urandom, $urandom, $urandom, $urandom};
        it            = noise[$bits(pixel_cmd_t)-1:0];
        it.func       = FUNC_DATA;
        it.data_value = dv;
        return it;
    endfunction

    // Offer one item, wait for it to be taken, then maybe leave a gap
    task automatic send(pixel_cmd_t it);
        cmd_ch.valid      <= 1'b1;
        cmd_ch.func       <= it.func;
        cmd_ch.mode       <= it.mode;
        cmd_ch.x_first    <= it.x_first;
        cmd_ch.y_first    <= it.y_first;
        cmd_ch.x_last     <= it.x_last;
        cmd_ch.y_last     <= it.y_last;
        cmd_ch.fore_color <= it.fore_color;
        cmd_ch.back_color <= it.back_color;
        cmd_ch.data_value <= it.data_value;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        if (sb.note_item(it) > 0)
            busy_items++;
        if (idle_on && $urandom_range(0, 9) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
    endtask

    // Start a window and follow it with a number of data items
    task automatic draw_window(logic [1:0] mode, int x1, int y1, int w, int h, int n);
        send(start_cmd(mode, 16'(x1), 16'(y1), 16'(x1 + w - 1), 16'(y1 + h - 1),
                       16'($urandom), 16'($urandom)));
        repeat (n) send(data_cmd(16'($urandom)));
    endtask

    // Random window with mostly small, sometimes extreme, geometry
    task automatic random_window();
        logic [1:0] mode;
        int w, h, x1, y1, need, n;
        mode = 2'($urandom_range(0, 2));
        case ($urandom_range(0, 19))
            0: begin w = $urandom_range(200, SCR_W); h = 1; end
            1: begin w = 1; h = $urandom_range(20, 60); end
            default: begin w = $urandom_range(1, 10); h = $urandom_range(1, 4); end
        endcase
        if ($urandom_range(0, 3) == 0)
            x1 = $urandom_range(0, 1) ? 0 : SCR_W - w;
        else
            x1 = $urandom_range(0, SCR_W - w);
        if ($urandom_range(0, 3) == 0)
            y1 = $urandom_range(0, 1) ? 0 : SCR_H - h;
        else
            y1 = $urandom_range(0, SCR_H - h);
        need = (mode == MODE_GLYPH) ? h * ((w + 7) / 8) : w * h;
        case ($urandom_range(0, 9))
            0: n = $urandom_range(0, need - 1);       // left open, abandoned later
            1: n = need + $urandom_range(1, 3);       // trailing items are ignored
            default: n = need;
        endcase
        draw_window(mode, x1, y1, w, h, n);
    endtask

    // Stimulus
    initial
    begin
        int base;
        rst_n             <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.func       <= FUNC_START;
        cmd_ch.mode       <= MODE_FILL;
        cmd_ch.x_first    <= '0;
        cmd_ch.y_first    <= '0;
        cmd_ch.x_last     <= '0;
        cmd_ch.y_last     <= '0;
        cmd_ch.fore_color <= '0;
        cmd_ch.back_color <= '0;
        cmd_ch.data_value <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: data with no window open is ignored
        send(data_cmd(16'hFFFF));
        // full screen fill, abandoned by the next start
        send(start_cmd(MODE_FILL, 0, 0, 16'(SCR_W - 1), 16'(SCR_H - 1),
                       16'hFFFF, 16'h0000));
        send(data_cmd(16'h0000));
        send(data_cmd(16'hFFFF));
        // single pixel in the far corner, then a stray item after it ends
        send(start_cmd(MODE_IMAGE, 16'(SCR_W - 1), 16'(SCR_H - 1), 16'(SCR_W - 1),
                       16'(SCR_H - 1), 16'h0000, 16'hFFFF));
        send(data_cmd(16'hFFFF));
        send(data_cmd(16'h1234));
        // windows that are dropped: off screen, reversed, unused mode
        send(start_cmd(MODE_FILL, 16'(SCR_W), 0, 16'(SCR_W), 0, 16'h1111, 16'h2222));
        send(start_cmd(MODE_FILL, 0, 0, 0, 16'(SCR_H), 16'h1111, 16'h2222));
        send(start_cmd(MODE_IMAGE, 5, 0, 4, 0, 16'h1111, 16'h2222));
        send(start_cmd(MODE_IMAGE, 0, 9, 0, 8, 16'h1111, 16'h2222));
        send(start_cmd(MODE_UNUSED, 0, 0, 3, 3, 16'h1111, 16'h2222));
        send(start_cmd(MODE_GLYPH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 16'hFFFF));
        // glyph 10 x 2: high byte ignored, rows end inside a byte
        send(start_cmd(MODE_GLYPH, 0, 0, 9, 1, 16'hF800, 16'h07E0));
        send(data_cmd(16'hFFA5));
        send(data_cmd(16'h00C0));
        send(data_cmd(16'h0000));
        send(data_cmd(16'h0080));
        // glyph 3 x 1: window ends part way through the byte
        send(start_cmd(MODE_GLYPH, 100, 200, 102, 200, 16'hFFFF, 16'h0000));
        send(data_cmd(16'h00E0));
        // fill ignores the data value
        send(start_cmd(MODE_FILL, 7, 7, 8, 7, 16'hABCD, 16'h0000));
        send(data_cmd(16'h5A5A));
        send(data_cmd(16'hA5A5));
        wait_drained();

        // Pressure: long receiver hold while the sender keeps offering items
        idle_on  = 1'b0;
        hold_req = 1'b1;
        draw_window(MODE_FILL, 16, 16, 8, 8, 64);
        wait_drained();
        idle_on = 1'b1;

        // Random windows, junk starts and stray data
        base = busy_items;
        while (busy_items - base < RANDOM_ITEMS)
        begin
            if (busy_items - base >= RANDOM_ITEMS - 50)
                idle_on = 1'b0;
            case ($urandom_range(0, 11))
                0: send(start_cmd(2'($urandom_range(0, 3)), 16'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom)));
                1: send(data_cmd(16'($urandom)));
                default: random_window();
            endcase
        end

        // Drain and let any stray words show up
        wait_drained();
        repeat (30) @(posedge clk);
        if (sb.errors == 0)
            $display("lcd_window_pixel_writer: match");
        else
            $display("lcd_window_pixel_writer: mismatch");
        $finish;
    end

endmodule
